### rtl/rae_pkg.sv
`default_nettype none

package rae_pkg;

	// Register file geometry.
	localparam int NUM_REGS = 32;
	localparam int RF_AW    = $clog2(NUM_REGS);

	// Field widths of the instruction and result beats.
	localparam int XLEN    = 64;
	localparam int HALF    = XLEN / 2;
	localparam int MODE_W  = 4;
	localparam int REG_W   = 5;
	localparam int IMM_W   = 16;
	localparam int SHIFT_W = 6;

	// Bit offsets of the fields in the slave-side tdata.
	localparam int OFS_DEST  = MODE_W;
	localparam int OFS_SRC_A = OFS_DEST + REG_W;
	localparam int OFS_SRC_B = OFS_SRC_A + REG_W;
	localparam int OFS_IMM   = OFS_SRC_B + REG_W;
	localparam int OFS_SHIFT = OFS_IMM + IMM_W;
	localparam int IN_BITS   = OFS_SHIFT + SHIFT_W;

	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((REG_W + XLEN + 7) / 8) * 8;
	localparam int M_TUSER_W = 2;

	// Decoded-instruction queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Operation codes as they arrive on the input stream.
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD  = 4'd0,
		MODE_SUB  = 4'd1,
		MODE_MUL  = 4'd2,
		MODE_ADDI = 4'd3,
		MODE_SUBI = 4'd4,
		MODE_AND  = 4'd5,
		MODE_ORR  = 4'd6,
		MODE_EOR  = 4'd7,
		MODE_ANDI = 4'd8,
		MODE_ORRI = 4'd9,
		MODE_EORI = 4'd10,
		MODE_MOVZ = 4'd11,
		MODE_MOVK = 4'd12,
		MODE_MOVN = 4'd13
	} mode_t;

	// Internal operation classes after decode.
	typedef enum logic [3:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_AND,
		ALU_ORR,
		ALU_EOR,
		ALU_MOVE,
		ALU_MOVK,
		ALU_BAD
	} alu_op_t;

	typedef logic [RF_AW-1:0] rf_addr_t;

	// One decoded instruction as it sits in the queue.
	typedef struct packed {
		alu_op_t          op;
		logic             use_imm;
		logic [REG_W-1:0] dest;
		logic [REG_W-1:0] src_a;
		logic [REG_W-1:0] src_b;
		logic             dest_ok;
		logic             a_ok;
		logic             b_ok;
		logic             use_a;
		logic             use_b;
		logic             use_d;
		logic [XLEN-1:0]  k;
		logic [XLEN-1:0]  keep_mask;
	} uop_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [REG_W-1:0] reg_idx;
		logic [XLEN-1:0]  value;
		logic             wrote;
		logic             bad_op;
	} result_t;

	// Register index to file address; only meaningful for indexes in range.
	function automatic rf_addr_t rf_addr(input logic [REG_W-1:0] idx);
		logic [RF_AW+REG_W-1:0] wide;
		wide = {{RF_AW{1'b0}}, idx};
		return wide[RF_AW-1:0];
	endfunction

	function automatic logic idx_ok(input logic [REG_W-1:0] idx);
		return 32'(idx) < 32'(NUM_REGS);
	endfunction

endpackage

`default_nettype wire

### rtl/rae_ram.sv
`default_nettype none

module rae_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; a read at the written
	// address returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/rae_front.sv
`default_nettype none

module rae_front (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rae_pkg::S_TDATA_W-1:0]  s_tdata,
	input  rae_pkg::q_status_t             q_status,
	output logic                           push,
	output rae_pkg::uop_t                  push_uop
);

	import rae_pkg::*;

	logic [MODE_W-1:0]  mode;
	logic [REG_W-1:0]   dest;
	logic [REG_W-1:0]   src_a;
	logic [REG_W-1:0]   src_b;
	logic [IMM_W-1:0]   imm;
	logic [SHIFT_W-1:0] sh;
	logic [XLEN-1:0]    imm64;
	logic [XLEN-1:0]    shifted;
	logic [XLEN-1:0]    field_mask;
	uop_t               u;

	// A beat is taken whenever the queue has room.
	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	assign mode  = s_tdata[OFS_DEST-1:0];
	assign dest  = s_tdata[OFS_SRC_A-1:OFS_DEST];
	assign src_a = s_tdata[OFS_SRC_B-1:OFS_SRC_A];
	assign src_b = s_tdata[OFS_IMM-1:OFS_SRC_B];
	assign imm   = s_tdata[OFS_SHIFT-1:OFS_IMM];
	assign sh    = s_tdata[IN_BITS-1:OFS_SHIFT];

	// Move-wide operand and the field it replaces; bits past the top are lost.
	assign imm64      = XLEN'(imm);
	assign shifted    = imm64 << sh;
	assign field_mask = XLEN'({IMM_W{1'b1}}) << sh;

	// Classify the operation and note which registers it reads.
	always_comb begin
		u           = '0;
		u.dest      = dest;
		u.src_a     = src_a;
		u.src_b     = src_b;
		u.dest_ok   = idx_ok(dest);
		u.a_ok      = idx_ok(src_a);
		u.b_ok      = idx_ok(src_b);
		u.keep_mask = ~field_mask;
		unique case (mode)
			MODE_ADD: begin
				u.op    = ALU_ADD;
				u.use_a = 1'b1;
				u.use_b = 1'b1;
			end
			MODE_SUB: begin
				u.op    = ALU_SUB;
				u.use_a = 1'b1;
				u.use_b = 1'b1;
			end
			MODE_MUL: begin
				u.op    = ALU_MUL;
				u.use_a = 1'b1;
				u.use_b = 1'b1;
			end
			MODE_AND: begin
				u.op    = ALU_AND;
				u.use_a = 1'b1;
				u.use_b = 1'b1;
			end
			MODE_ORR: begin
				u.op    = ALU_ORR;
				u.use_a = 1'b1;
				u.use_b = 1'b1;
			end
			MODE_EOR: begin
				u.op    = ALU_EOR;
				u.use_a = 1'b1;
				u.use_b = 1'b1;
			end
			MODE_ADDI: begin
				u.op      = ALU_ADD;
				u.use_a   = 1'b1;
				u.use_imm = 1'b1;
				u.k       = imm64;
			end
			MODE_SUBI: begin
				u.op      = ALU_SUB;
				u.use_a   = 1'b1;
				u.use_imm = 1'b1;
				u.k       = imm64;
			end
			MODE_ANDI: begin
				u.op      = ALU_AND;
				u.use_a   = 1'b1;
				u.use_imm = 1'b1;
				u.k       = imm64;
			end
			MODE_ORRI: begin
				u.op      = ALU_ORR;
				u.use_a   = 1'b1;
				u.use_imm = 1'b1;
				u.k       = imm64;
			end
			MODE_EORI: begin
				u.op      = ALU_EOR;
				u.use_a   = 1'b1;
				u.use_imm = 1'b1;
				u.k       = imm64;
			end
			MODE_MOVZ: begin
				u.op = ALU_MOVE;
				u.k  = shifted;
			end
			MODE_MOVN: begin
				u.op = ALU_MOVE;
				u.k  = ~shifted;
			end
			MODE_MOVK: begin
				u.op    = ALU_MOVK;
				u.use_d = 1'b1;
				u.k     = shifted;
			end
			default: begin
				// Unimplemented: reports register zero and writes nothing.
				u.op      = ALU_BAD;
				u.dest    = '0;
				u.dest_ok = 1'b0;
			end
		endcase
	end

	assign push_uop = u;

endmodule

`default_nettype wire

### rtl/rae_queue.sv
`default_nettype none

module rae_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rae_pkg::uop_t      push_uop,
	input  logic               pop,
	output rae_pkg::uop_t      head,
	output rae_pkg::q_status_t q_status
);

	import rae_pkg::*;

	uop_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_uop;
		end
	end

	assign head           = mem_q[rd_ptr_q];
	assign q_status.full  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

endmodule

`default_nettype wire

### rtl/rae_back.sv
`default_nettype none

module rae_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rae_pkg::q_status_t q_status,
	input  rae_pkg::uop_t      head,
	output logic               pop,
	output logic               m_valid,
	input  logic               m_ready,
	output rae_pkg::result_t   m_result
);

	import rae_pkg::*;

	logic             adv;
	logic             issue;
	logic             hazard;
	logic             y_wr;
	logic             wr_en;

	// Operand stage.
	logic             v_s1;
	uop_t             uop_s1;
	logic             a_vld_s1;
	logic             b_vld_s1;
	logic             d_vld_s1;
	logic [XLEN-1:0]  a_ram;
	logic [XLEN-1:0]  b_ram;
	logic [XLEN-1:0]  d_ram;
	rf_addr_t         ra_addr;
	rf_addr_t         rb_addr;
	rf_addr_t         rd_addr;
	logic [XLEN-1:0]  opa;
	logic [XLEN-1:0]  opb;
	logic [XLEN-1:0]  opd;
	logic [XLEN-1:0]  opb_eff;
	logic [XLEN-1:0]  res_s1;
	logic [XLEN-1:0]  p_ll;
	logic [HALF-1:0]  p_lh;
	logic [HALF-1:0]  p_hl;

	// Completion stage.
	logic             v_s2;
	alu_op_t          op_s2;
	logic [REG_W-1:0] dest_s2;
	logic             dest_ok_s2;
	logic [XLEN-1:0]  res_s2;
	logic [HALF-1:0]  x1_s2;
	logic [HALF-1:0]  x2_s2;
	logic [XLEN-1:0]  final_val;

	// Register file state and bypass of the most recent write.
	logic [NUM_REGS-1:0] rf_vld_q;
	logic                lw_v_q;
	logic [REG_W-1:0]    lw_reg_q;
	logic [XLEN-1:0]     lw_val_q;

	logic             m_valid_q;
	result_t          m_result_q;

	// Newest value wins: the completion stage, then the last write,
	// then the file itself; an entry never written reads as zero.
	function automatic logic [XLEN-1:0] pick_operand(
		input logic [REG_W-1:0] idx,
		input logic             ok,
		input logic [XLEN-1:0]  ram_val,
		input logic             vld,
		input logic             y_en,
		input logic [REG_W-1:0] y_reg,
		input logic [XLEN-1:0]  y_val,
		input logic             lw_en,
		input logic [REG_W-1:0] lw_reg,
		input logic [XLEN-1:0]  lw_val
	);
		logic [XLEN-1:0] v;
		if (!ok) begin
			v = '0;
		end else if (y_en && (y_reg == idx)) begin
			v = y_val;
		end else if (lw_en && (lw_reg == idx)) begin
			v = lw_val;
		end else if (vld) begin
			v = ram_val;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	// The whole back end moves when the output register can take a beat.
	assign adv  = !m_valid_q || m_ready;
	assign y_wr = v_s2 && dest_ok_s2;

	// A product is only complete at the end of the completion stage, so a
	// reader of it is held in the operand stage.
	assign hazard = v_s1 && y_wr && (op_s2 == ALU_MUL) &&
		((uop_s1.use_a && uop_s1.a_ok && (uop_s1.src_a == dest_s2)) ||
		 (uop_s1.use_b && uop_s1.b_ok && (uop_s1.src_b == dest_s2)) ||
		 (uop_s1.use_d && uop_s1.dest_ok && (uop_s1.dest == dest_s2)));

	assign issue = adv && !hazard;
	assign pop   = issue && !q_status.empty;

	// Read addresses follow the queue head on issue and re-read for a
	// held instruction otherwise.
	assign ra_addr = issue ? rf_addr(head.src_a) : rf_addr(uop_s1.src_a);
	assign rb_addr = issue ? rf_addr(head.src_b) : rf_addr(uop_s1.src_b);
	assign rd_addr = issue ? rf_addr(head.dest)  : rf_addr(uop_s1.dest);

	assign wr_en = adv && y_wr;

	// Three copies of the register file give three read ports.
	rae_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rf_addr(dest_s2)),
		.wdata (final_val),
		.raddr (ra_addr),
		.rdata (a_ram)
	);

	rae_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rf_addr(dest_s2)),
		.wdata (final_val),
		.raddr (rb_addr),
		.rdata (b_ram)
	);

	rae_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_d (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rf_addr(dest_s2)),
		.wdata (final_val),
		.raddr (rd_addr),
		.rdata (d_ram)
	);

	// Written-entry flags, looked up alongside the file read.
	always_ff @(posedge clk) begin
		a_vld_s1 <= rf_vld_q[ra_addr];
		b_vld_s1 <= rf_vld_q[rb_addr];
		d_vld_s1 <= rf_vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			lw_v_q   <= 1'b0;
		end else if (wr_en) begin
			rf_vld_q[rf_addr(dest_s2)] <= 1'b1;
			lw_v_q                     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_reg_q <= dest_s2;
			lw_val_q <= final_val;
		end
	end

	// Operand stage: resolve sources and evaluate.
	assign opa = pick_operand(uop_s1.src_a, uop_s1.a_ok, a_ram, a_vld_s1,
		y_wr, dest_s2, res_s2, lw_v_q, lw_reg_q, lw_val_q);
	assign opb = pick_operand(uop_s1.src_b, uop_s1.b_ok, b_ram, b_vld_s1,
		y_wr, dest_s2, res_s2, lw_v_q, lw_reg_q, lw_val_q);
	assign opd = pick_operand(uop_s1.dest, uop_s1.dest_ok, d_ram, d_vld_s1,
		y_wr, dest_s2, res_s2, lw_v_q, lw_reg_q, lw_val_q);

	assign opb_eff = uop_s1.use_imm ? uop_s1.k : opb;

	// Low 64 bits of the product from three 32-bit partial products.
	assign p_ll = XLEN'(opa[HALF-1:0]) * XLEN'(opb[HALF-1:0]);
	assign p_lh = opa[HALF-1:0] * opb[XLEN-1:HALF];
	assign p_hl = opa[XLEN-1:HALF] * opb[HALF-1:0];

	always_comb begin
		case (uop_s1.op)
			ALU_ADD:  res_s1 = opa + opb_eff;
			ALU_SUB:  res_s1 = opa - opb_eff;
			ALU_MUL:  res_s1 = p_ll;
			ALU_AND:  res_s1 = opa & opb_eff;
			ALU_ORR:  res_s1 = opa | opb_eff;
			ALU_EOR:  res_s1 = opa ^ opb_eff;
			ALU_MOVE: res_s1 = uop_s1.k;
			ALU_MOVK: res_s1 = (opd & uop_s1.keep_mask) | uop_s1.k;
			default:  res_s1 = '0;
		endcase
	end

	// Completion stage: fold the cross products into the upper half.
	assign final_val = (op_s2 == ALU_MUL) ?
		{res_s2[XLEN-1:HALF] + x1_s2 + x2_s2, res_s2[HALF-1:0]} : res_s2;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= v_s2;
			v_s2      <= v_s1 && !hazard;
			if (!hazard) begin
				v_s1 <= !q_status.empty;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (issue) begin
			uop_s1 <= head;
		end
		if (adv) begin
			op_s2      <= uop_s1.op;
			dest_s2    <= uop_s1.dest;
			dest_ok_s2 <= uop_s1.dest_ok;
			res_s2     <= res_s1;
			x1_s2      <= p_lh;
			x2_s2      <= p_hl;

			m_result_q.reg_idx <= dest_s2;
			m_result_q.value   <= final_val;
			m_result_q.wrote   <= dest_ok_s2;
			m_result_q.bad_op  <= (op_s2 == ALU_BAD);
		end
	end

	assign m_valid  = m_valid_q;
	assign m_result = m_result_q;

endmodule

`default_nettype wire

### rtl/register_alu_execute_unit.sv
// An accepted input beat passes through the queue, the operand stage, the
// completion stage and the output register on its way to its result beat.
// Throughput: one beat per cycle while the output is ready; an instruction that
// reads the result of the multiply just ahead of it is held in the operand stage.
// Reset clears the written-entry flags of the register file, so every register
// reads as zero at once, and empties the queue, pipeline and output register.
`default_nettype none

module register_alu_execute_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// mode, dest_reg, src_a, src_b, immediate, shift_amount, zero pad
	input  logic [rae_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// written_reg, written_value, zero pad
	output logic [rae_pkg::M_TDATA_W-1:0]  m_tdata,
	// wrote, bad_op
	output logic [rae_pkg::M_TUSER_W-1:0]  m_tuser
);

	import rae_pkg::*;

	q_status_t q_status;
	logic      push;
	uop_t      push_uop;
	logic      pop;
	uop_t      head;
	result_t   m_result;

	// Front: accept and decode.
	rae_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_status (q_status),
		.push     (push),
		.push_uop (push_uop)
	);

	// Queue of decoded instructions.
	rae_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_uop (push_uop),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	// Back: register file, execute and result beat.
	rae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_result (m_result)
	);

	// Result beat packing.
	assign m_tdata = {{(M_TDATA_W - REG_W - XLEN){1'b0}}, m_result.value, m_result.reg_idx};
	assign m_tuser = {m_result.bad_op, m_result.wrote};

	// The queue is never written when full.
	assert property (@(posedge clk) disable iff (!arst_n) q_status.full |-> !push)
		else $error("queue written while full");

	// The queue is never read when empty.
	assert property (@(posedge clk) disable iff (!arst_n) q_status.empty |-> !pop)
		else $error("queue read while empty");

	// An unimplemented operation reports register zero, value zero and no write.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_result.bad_op) |->
		(!m_result.wrote && (m_result.reg_idx == '0) && (m_result.value == '0)))
		else $error("unimplemented operation reported a write");

endmodule

`default_nettype wire

### bench/tb_register_alu_execute_unit.sv
`timescale 1ns / 1ps

module tb_register_alu_execute_unit;
	import rae_pkg::*;

	// Operation codes that the unit does not implement.
	localparam logic [MODE_W-1:0] MODE_UNDEF_14 = 4'd14;
	localparam logic [MODE_W-1:0] MODE_UNDEF_15 = 4'd15;

	localparam int RANDOM_BEATS = 925;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AT      = 150;
	localparam int DRAIN_AT     = 350;
	localparam int BURST_FROM   = 500;
	localparam int BURST_TO     = 700;
	localparam int STALL_LIMIT  = 1000;

	// One instruction, laid out exactly as the low bits of s_tdata:
	// mode lowest, then dest_reg, src_a, src_b, immediate, shift_amount.
	typedef struct packed {
		logic [SHIFT_W-1:0] sh;
		logic [IMM_W-1:0]   imm;
		logic [REG_W-1:0]   rb;
		logic [REG_W-1:0]   ra;
		logic [REG_W-1:0]   rd;
		logic [MODE_W-1:0]  op;
	} instr_t;

	// A result typed in by hand for a directed row, if any.
	typedef struct packed {
		logic    on;
		result_t want;
	} fixed_result_t;

	typedef struct packed {
		instr_t        ins;
		fixed_result_t fixed;
	} dir_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// Shadow register file and the queues of the scoreboard.
	logic [XLEN-1:0] gpr_shadow [NUM_REGS];
	result_t         pending_results [$];
	fixed_result_t   fixed_tags [$];
	dir_row_t        directed_rows [$];
	logic [REG_W-1:0] last_dest [4];

	int unsigned errors       = 0;
	int unsigned beats_in     = 0;
	int unsigned beats_out    = 0;
	int unsigned bad_ops      = 0;
	int unsigned stall_cycles = 0;
	bit          burst        = 1'b0;
	bit          hold_req     = 1'b0;
	bit          hold_seen    = 1'b0;

	register_alu_execute_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected result of one instruction against the shadow register file.
	function automatic result_t alu_predict(input instr_t ins);
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] imm64;
		logic [XLEN-1:0] shifted;
		logic [XLEN-1:0] old_dest;
		logic [XLEN-1:0] v;
		result_t         r;
		a        = (32'(ins.ra) < NUM_REGS) ? gpr_shadow[ins.ra] : '0;
		b        = (32'(ins.rb) < NUM_REGS) ? gpr_shadow[ins.rb] : '0;
		old_dest = (32'(ins.rd) < NUM_REGS) ? gpr_shadow[ins.rd] : '0;
		imm64    = XLEN'(ins.imm);
		shifted  = imm64 << ins.sh;
		r.reg_idx = ins.rd;
		r.wrote   = 32'(ins.rd) < NUM_REGS;
		r.bad_op  = 1'b0;
		v         = '0;
		case (ins.op)
			MODE_ADD:  v = a + b;
			MODE_SUB:  v = a - b;
			MODE_MUL:  v = a * b;
			MODE_ADDI: v = a + imm64;
			MODE_SUBI: v = a - imm64;
			MODE_AND:  v = a & b;
			MODE_ORR:  v = a | b;
			MODE_EOR:  v = a ^ b;
			MODE_ANDI: v = a & imm64;
			MODE_ORRI: v = a | imm64;
			MODE_EORI: v = a ^ imm64;
			MODE_MOVZ: v = shifted;
			MODE_MOVK: v = (old_dest & ~(XLEN'(16'hFFFF) << ins.sh)) | shifted;
			MODE_MOVN: v = ~shifted;
			default: begin
				r.reg_idx = '0;
				r.wrote   = 1'b0;
				r.bad_op  = 1'b1;
			end
		endcase
		r.value = v;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [XLEN-1:0] want,
			input logic [XLEN-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Scoreboard: predict on every accepted instruction beat, check every result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_out++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, got %h / %b",
						$realtime, m_tdata, m_tuser);
				end else begin
					result_t want;
					want = pending_results.pop_front();
					check_field("written_reg", XLEN'(want.reg_idx), XLEN'(m_tdata[0 +: REG_W]));
					check_field("written_value", want.value, m_tdata[REG_W +: XLEN]);
					check_field("wrote", XLEN'(want.wrote), XLEN'(m_tuser[0]));
					check_field("bad_op", XLEN'(want.bad_op), XLEN'(m_tuser[1]));
				end
			end
			if (s_tvalid && s_tready) begin
				result_t       got;
				fixed_result_t tag;
				got = alu_predict(instr_t'(s_tdata[$bits(instr_t)-1:0]));
				if (got.wrote)
					gpr_shadow[got.reg_idx] = got.value;
				if (got.bad_op)
					bad_ops++;
				tag = fixed_tags.pop_front();
				pending_results.push_back(tag.on ? tag.want : got);
				beats_in++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog on cycles with no beat moving on either side.
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
		$display("tb_register_alu_execute_unit: done, errors");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off, none during the burst window.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_seen = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= burst || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	// Offer one instruction beat and wait until it is taken, then maybe idle.
	task automatic send_instr(input instr_t ins, input fixed_result_t fixed);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(ins);
		fixed_tags.push_back(fixed);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gap = 0;
		if (!burst)
			while ($urandom_range(0, 99) < 36)
				gap++;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop offering until every expected result has come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(input logic [MODE_W-1:0] op, input int rd, input int ra,
			input int rb, input logic [IMM_W-1:0] imm, input int sh, input bit typed,
			input logic [XLEN-1:0] want);
		dir_row_t row;
		row.ins       = '{sh: SHIFT_W'(sh), imm: imm, rb: REG_W'(rb), ra: REG_W'(ra),
			rd: REG_W'(rd), op: op};
		row.fixed.on  = typed;
		if (op == MODE_UNDEF_14 || op == MODE_UNDEF_15)
			row.fixed.want = '{reg_idx: '0, value: '0, wrote: 1'b0, bad_op: 1'b1};
		else
			row.fixed.want = '{reg_idx: REG_W'(rd), value: want, wrote: 1'b1, bad_op: 1'b0};
		directed_rows.push_back(row);
	endtask

	// Random instruction; sources lean on recent destinations to create dependences.
	function automatic instr_t rand_instr();
		instr_t ins;
		int     pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			ins.op = $urandom_range(0, 1) ? MODE_UNDEF_15 : MODE_UNDEF_14;
		else
			ins.op = MODE_W'($urandom_range(0, 13));
		ins.rd = REG_W'($urandom_range(0, 31));
		ins.ra = ($urandom_range(0, 99) < 60) ? last_dest[$urandom_range(0, 3)]
			: REG_W'($urandom_range(0, 31));
		ins.rb = ($urandom_range(0, 99) < 60) ? last_dest[$urandom_range(0, 3)]
			: REG_W'($urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		ins.imm = (pick < 10) ? '0 : (pick < 20) ? '1 : IMM_W'($urandom());
		pick = $urandom_range(0, 99);
		ins.sh = (pick < 8) ? '0 : (pick < 16) ? SHIFT_W'(63) : (pick < 24) ? SHIFT_W'(48)
			: SHIFT_W'($urandom_range(0, 63));
		return ins;
	endfunction

	initial begin
		fixed_result_t no_fix;
		instr_t        ins;
		no_fix = '0;
		foreach (gpr_shadow[i])
			gpr_shadow[i] = '0;
		foreach (last_dest[i])
			last_dest[i] = '0;

		// Directed rows: extremes, every operation, undefined codes, dependences.
		add_row(MODE_ADD,   0,  1,  2, 16'h0000,  0, 1, 64'h0);
		add_row(MODE_MOVN,  1,  0,  0, 16'h0000,  0, 1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_row(MODE_MOVZ,  2,  0,  0, 16'hFFFF,  0, 1, 64'h0000_0000_0000_FFFF);
		add_row(MODE_MOVZ,  3,  0,  0, 16'hFFFF, 63, 1, 64'h8000_0000_0000_0000);
		add_row(MODE_MOVZ,  4,  0,  0, 16'hFFFF, 48, 1, 64'hFFFF_0000_0000_0000);
		add_row(MODE_ADD,   5,  1,  2, 16'h0000,  0, 0, '0);
		add_row(MODE_SUB,   6,  0,  2, 16'h0000,  0, 0, '0);
		add_row(MODE_MUL,   7,  1,  1, 16'h0000,  0, 0, '0);
		add_row(MODE_MUL,   8,  4,  4, 16'h0000,  0, 0, '0);
		add_row(MODE_ADDI,  9,  1,  0, 16'hFFFF,  0, 0, '0);
		add_row(MODE_SUBI, 10,  0,  0, 16'h0001,  0, 1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_row(MODE_AND,  11,  1,  3, 16'h0000,  0, 0, '0);
		add_row(MODE_ORR,  12,  2,  3, 16'h0000,  0, 0, '0);
		add_row(MODE_EOR,  13,  1,  2, 16'h0000,  0, 0, '0);
		add_row(MODE_ANDI, 14,  1,  0, 16'hA5A5,  0, 0, '0);
		add_row(MODE_ORRI, 15,  3,  0, 16'hFFFF,  0, 0, '0);
		add_row(MODE_EORI, 16,  1,  0, 16'hFFFF,  0, 0, '0);
		add_row(MODE_MOVK,  1,  0,  0, 16'h1234, 16, 0, '0);
		add_row(MODE_MOVK,  3,  0,  0, 16'hFFFF, 60, 0, '0);
		add_row(MODE_MOVN, 17,  0,  0, 16'hFFFF, 63, 1, 64'h7FFF_FFFF_FFFF_FFFF);
		add_row(MODE_MOVK, 31,  0,  0, 16'h0005,  0, 0, '0);
		add_row(MODE_UNDEF_14, 20, 1, 2, 16'hFFFF, 63, 1, '0);
		add_row(MODE_UNDEF_15, 31, 31, 31, 16'h0000, 0, 1, '0);
		add_row(MODE_MUL,  20,  1,  4, 16'h0000,  0, 0, '0);
		add_row(MODE_ADD,  31, 20, 20, 16'h0000,  0, 0, '0);

		// Hold reset, then release it.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_instr(directed_rows[i].ins, directed_rows[i].fixed);
		drain_results();

		// Random instruction stream.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			burst = (n >= BURST_FROM) && (n < BURST_TO);
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == DRAIN_AT)
				drain_results();
			ins = rand_instr();
			last_dest[n % 4] = ins.rd;
			send_instr(ins, no_fix);
		end
		burst = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d instruction beats (%0d undefined codes) and %0d result beats,",
			beats_in, bad_ops, beats_out);
		$display("with a %0d-cycle result hold-off (%0s) and a back-to-back burst window.",
			HOLD_CYCLES, hold_seen ? "taken" : "missed");
		if (errors == 0)
			$display("tb_register_alu_execute_unit: done, clean");
		else
			$display("tb_register_alu_execute_unit: done, errors");
		$finish;
	end

endmodule
